// File: rtl/vpri_pkg.sv
// ----------------------------------------------------------------------------
// vpri_pkg: shared types and constants for the video port register interface
// Port access codes, address codes, register reset image and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vpri_pkg;

   // port access kinds
   typedef enum logic [1:0] {
      OP_CTRL_READ  = 2'd0,
      OP_DATA_READ  = 2'd1,
      OP_CTRL_WRITE = 2'd2,
      OP_DATA_WRITE = 2'd3
   } op_type;

   // code field, bits 15..14 of the address word
   typedef enum logic [1:0] {
      CODE_VRAM_READ  = 2'd0,
      CODE_VRAM_WRITE = 2'd1,
      CODE_REG_WRITE  = 2'd2,
      CODE_COLOR      = 2'd3
   } code_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DISPATCH,
      ST_FETCH,
      ST_COLOR_WRITE,
      ST_DONE
   } state_type;

   localparam int          ADDR_BITS     = 14;
   localparam logic [15:0] ADDR_RESET    = 16'hBF00;
   localparam int          NUM_VREGS     = 16;
   localparam int          VREG_IDX_BITS = 4;
   localparam logic [1:0]  ENABLE_RESET  = 2'b11;
   localparam int          VREG_FRAME_EN = 1;   // register holding frame enable
   localparam int          VREG_LINE_EN  = 0;   // register holding line enable
   localparam int          FRAME_EN_BIT  = 5;   // mask 0x20
   localparam int          LINE_EN_BIT   = 4;   // mask 0x10

   typedef logic [7:0] vreg_array_type [NUM_VREGS];

   localparam vreg_array_type VREG_RESET = '{
      8'h26, 8'hE0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // controller to datapath
   typedef struct packed {
      logic latch;        // take the new beat, merge renderer flags
      logic ctl_read;     // return status, clear status and pending
      logic data_read;    // return buffer, start memory read
      logic lo_byte;      // first control byte
      logic hi_byte;      // second control byte
      logic fetch_issue;  // prefetch memory read for code 0
      logic buf_fill;     // buffer from memory, advance address
      logic reg_write;    // video register write
      logic vram_write;   // memory write, buffer, advance
      logic color_calc;   // color index quotient estimate
      logic color_write;  // color write, buffer, advance
      logic load_out;     // move result into output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type   op;
      logic     second;
      code_type code;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/vpri_ctrl.sv
// ----------------------------------------------------------------------------
// vpri_ctrl: access sequencer
// Steps each accepted beat through execute and, as its kind needs, dispatch,
// memory fetch or color write states, and owns the input stall and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module vpri_ctrl
   import vpri_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (status.op)
               OP_CTRL_READ: begin
                  cmd.ctl_read = 1'b1;
                  state_in     = ST_DONE;
               end
               OP_DATA_READ: begin
                  cmd.data_read = 1'b1;
                  state_in      = ST_FETCH;
               end
               OP_CTRL_WRITE: begin
                  if (status.second) begin
                     cmd.hi_byte = 1'b1;
                     state_in    = ST_DISPATCH;
                  end else begin
                     cmd.lo_byte = 1'b1;
                     state_in    = ST_DONE;
                  end
               end
               OP_DATA_WRITE: begin
                  if (status.code == CODE_COLOR) begin
                     cmd.color_calc = 1'b1;
                     state_in       = ST_COLOR_WRITE;
                  end else begin
                     cmd.vram_write = 1'b1;
                     state_in       = ST_DONE;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_DISPATCH: begin
            priority case (status.code)
               CODE_VRAM_READ: begin
                  cmd.fetch_issue = 1'b1;
                  state_in        = ST_FETCH;
               end
               CODE_REG_WRITE: begin
                  cmd.reg_write = 1'b1;
                  state_in      = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_FETCH: begin
            cmd.buf_fill = 1'b1;
            state_in     = ST_DONE;
         end
         ST_COLOR_WRITE: begin
            cmd.color_write = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            // wait for room in the output register
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output valid: set on load, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // an accepted beat always goes to execute
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not enter execute");

   // memory fetch only follows a read issue
   a_fetch_src: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |->
         ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_DISPATCH))
      else $error("fetch state entered without a read issue");

   // finishing a beat presents a result
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("result not presented after completion");
`endif

endmodule

`default_nettype wire

// File: rtl/vpri_datapath.sv
// ----------------------------------------------------------------------------
// vpri_datapath: address word, read buffer, status, video registers, memories
// Executes the commands of the sequencer and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vpri_datapath
   import vpri_pkg::*;
#(
   parameter int VRAM_ADDR_BITS = 14,
   parameter int CRAM_DEPTH     = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctrl_cmd_type cmd,
   output dp_status_type     status,
   input  wire logic [1:0]   req_op,
   input  wire logic [7:0]   req_data_in,
   input  wire logic [7:0]   req_status_set,
   input  wire logic [1:0]   req_irq_raise,
   output logic [7:0]        rsp_read_data,
   output logic [1:0]        rsp_irq_pending,
   output logic [1:0]        rsp_irq_enable,
   output logic              rsp_reg_written,
   output logic [3:0]        rsp_reg_index,
   output logic [7:0]        rsp_reg_value
);

   localparam int VRAM_DEPTH  = 1 << VRAM_ADDR_BITS;
   localparam int CRAM_AW     = $clog2(CRAM_DEPTH);
   localparam int CRAM_SHIFT  = 20;
   localparam int CRAM_RECIP  = (1 << CRAM_SHIFT) / CRAM_DEPTH;
   localparam int PROD_W      = ADDR_BITS + CRAM_SHIFT + 1;
   localparam int RES_W       = ADDR_BITS + 8;

   // control state
   logic [15:0]    addr_ff, addr_in;
   logic           second_ff, second_in;
   logic [7:0]     status_ff, status_in;
   logic [1:0]     pending_ff, pending_in;
   logic [1:0]     enable_ff, enable_in;
   vreg_array_type vreg_ff, vreg_in;

   // payload
   op_type         op_ff;
   logic [7:0]     din_ff;
   logic [7:0]     buffer_ff, buffer_in;
   logic [7:0]     rdata_ff, rdata_in;
   logic           wr_ff, wr_in;
   logic [3:0]     widx_ff, widx_in;
   logic [7:0]     wval_ff, wval_in;
   logic [7:0]     vram_q_ff;
   logic [ADDR_BITS-1:0] quot_ff;

   logic [7:0] vram_mem  [VRAM_DEPTH];
   logic [7:0] color_mem [CRAM_DEPTH];

   logic [15:0]          addr_next;
   logic [ADDR_BITS-1:0] addr_low;
   logic [PROD_W-1:0]    quot_prod;
   logic [RES_W-1:0]     quot_back;
   logic [RES_W-1:0]     resid_full;
   logic [CRAM_AW:0]     resid;
   logic [CRAM_AW:0]     resid_fix;
   logic [3:0]           vidx;
   logic [7:0]           reg0_new, reg1_new;

   assign addr_low  = addr_ff[ADDR_BITS-1:0];
   assign addr_next = {addr_ff[15:ADDR_BITS], addr_low + ADDR_BITS'(1)};
   assign vidx      = addr_ff[11:8];

   // color index: address modulo depth by reciprocal, one correction step
   assign quot_prod  = PROD_W'(addr_low) * PROD_W'(CRAM_RECIP);
   assign quot_back  = RES_W'(quot_ff) * RES_W'(CRAM_DEPTH);
   assign resid_full = RES_W'(addr_low) - quot_back;
   assign resid      = resid_full[CRAM_AW:0];
   always_comb begin
      resid_fix = resid;
      if (resid >= (CRAM_AW+1)'(CRAM_DEPTH)) begin
         resid_fix = resid - (CRAM_AW+1)'(CRAM_DEPTH);
      end
   end

   // enable bits follow the registers after a write
   assign reg0_new = (vidx == 4'(VREG_LINE_EN))  ? addr_ff[7:0] : vreg_ff[VREG_LINE_EN];
   assign reg1_new = (vidx == 4'(VREG_FRAME_EN)) ? addr_ff[7:0] : vreg_ff[VREG_FRAME_EN];

   // next state
   always_comb begin
      addr_in    = addr_ff;
      second_in  = second_ff;
      status_in  = status_ff;
      pending_in = pending_ff;
      enable_in  = enable_ff;
      vreg_in    = vreg_ff;
      buffer_in  = buffer_ff;
      rdata_in   = rdata_ff;
      wr_in      = wr_ff;
      widx_in    = widx_ff;
      wval_in    = wval_ff;
      if (cmd.latch) begin
         status_in  = status_ff | req_status_set;
         pending_in = pending_ff | req_irq_raise;
         rdata_in   = '0;
         wr_in      = 1'b0;
         widx_in    = '0;
         wval_in    = '0;
      end
      if (cmd.ctl_read) begin
         second_in  = 1'b0;
         rdata_in   = status_ff;
         status_in  = '0;
         pending_in = '0;
      end
      if (cmd.data_read) begin
         second_in = 1'b0;
         rdata_in  = buffer_ff;
      end
      if (cmd.lo_byte) begin
         addr_in   = {addr_ff[15:8], din_ff};
         second_in = 1'b1;
      end
      if (cmd.hi_byte) begin
         addr_in   = {din_ff, addr_ff[7:0]};
         second_in = 1'b0;
      end
      if (cmd.buf_fill) begin
         buffer_in = vram_q_ff;
         addr_in   = addr_next;
      end
      if (cmd.reg_write) begin
         vreg_in[vidx] = addr_ff[7:0];
         wr_in         = 1'b1;
         widx_in       = vidx;
         wval_in       = addr_ff[7:0];
         enable_in     = {reg0_new[LINE_EN_BIT], reg1_new[FRAME_EN_BIT]};
      end
      if (cmd.vram_write || cmd.color_write) begin
         second_in = 1'b0;
         buffer_in = din_ff;
         addr_in   = addr_next;
      end
      if (cmd.color_calc) begin
         second_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= ADDR_RESET;
         second_ff  <= 1'b0;
         status_ff  <= '0;
         pending_ff <= '0;
         enable_ff  <= ENABLE_RESET;
         vreg_ff    <= VREG_RESET;
         buffer_ff  <= '0;
      end else begin
         addr_ff    <= addr_in;
         second_ff  <= second_in;
         status_ff  <= status_in;
         pending_ff <= pending_in;
         enable_ff  <= enable_in;
         vreg_ff    <= vreg_in;
         buffer_ff  <= buffer_in;
      end
   end

   // beat payload and result
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= op_type'(req_op);
         din_ff <= req_data_in;
      end
      if (cmd.color_calc) begin
         quot_ff <= quot_prod[CRAM_SHIFT +: ADDR_BITS];
      end
      rdata_ff <= rdata_in;
      wr_ff    <= wr_in;
      widx_ff  <= widx_in;
      wval_ff  <= wval_in;
   end

   // video memory, single port
   always_ff @(posedge clock) begin
      if (cmd.vram_write) begin
         vram_mem[addr_ff[VRAM_ADDR_BITS-1:0]] <= din_ff;
      end
      if (cmd.data_read || cmd.fetch_issue) begin
         vram_q_ff <= vram_mem[addr_ff[VRAM_ADDR_BITS-1:0]];
      end
   end

   // color memory
   always_ff @(posedge clock) begin
      if (cmd.color_write) begin
         color_mem[resid_fix[CRAM_AW-1:0]] <= din_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_read_data   <= rdata_ff;
         rsp_irq_pending <= pending_ff;
         rsp_irq_enable  <= enable_ff;
         rsp_reg_written <= wr_ff;
         rsp_reg_index   <= widx_ff;
         rsp_reg_value   <= wval_ff;
      end
   end

   assign status.op     = op_ff;
   assign status.second = second_ff;
   assign status.code   = code_type'(addr_ff[15:14]);

endmodule

`default_nettype wire

// File: rtl/video_port_register_interface.sv
// ----------------------------------------------------------------------------
// video_port_register_interface: control and data port pair of a video
// processor. Address/code loading, read buffer, video registers, status and
// interrupt bits, video and color memory writes.
//
// channel  ports                                   direction
// req      req_valid req_stall req_op req_data_in  in
//          req_status_set req_irq_raise
// rsp      rsp_valid rsp_stall rsp_read_data       out
//          rsp_irq_pending rsp_irq_enable rsp_reg_written
//          rsp_reg_index rsp_reg_value
//
// One beat at a time. After the accepting edge the sequencer goes through
// execute, then fetch for a data read, dispatch for a second control byte
// (then fetch for code 0), the color write state for a color write, and
// then done; rsp_valid rises after done. The next beat is taken once the
// sequencer is back in idle. The registered memory read and the registered
// color index quotient need these extra states.
// Synchronous active-high reset; memories are not cleared.
// The output register holds a result under rsp_stall; a finished beat waits
// for it before the next beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module video_port_register_interface
   import vpri_pkg::*;
#(
   parameter int VRAM_ADDR_BITS = 14,
   parameter int CRAM_DEPTH     = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_data_in,
   input  wire logic [7:0] req_status_set,
   input  wire logic [1:0] req_irq_raise,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic [1:0]      rsp_irq_pending,
   output logic [1:0]      rsp_irq_enable,
   output logic            rsp_reg_written,
   output logic [3:0]      rsp_reg_index,
   output logic [7:0]      rsp_reg_value
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   vpri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // registers and memories
   vpri_datapath #(
      .VRAM_ADDR_BITS (VRAM_ADDR_BITS),
      .CRAM_DEPTH     (CRAM_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_data_in     (req_data_in),
      .req_status_set  (req_status_set),
      .req_irq_raise   (req_irq_raise),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_pending (rsp_irq_pending),
      .rsp_irq_enable  (rsp_irq_enable),
      .rsp_reg_written (rsp_reg_written),
      .rsp_reg_index   (rsp_reg_index),
      .rsp_reg_value   (rsp_reg_value)
   );

endmodule

`default_nettype wire
